// ===== hdl/lzsd_pkg.sv =====
package lzsd_pkg;

  // request kinds carried in the slave-side tuser
  localparam logic [1:0] REQ_FEED  = 2'd0;
  localparam logic [1:0] REQ_PULL  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_BAD   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;
  localparam logic [1:0] ST_WRONG   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_LIMIT = 2'd0;
  localparam logic [1:0] CFG_FIXED = 2'd1;
  localparam logic [1:0] CFG_START = 2'd2;

  // header codes
  localparam logic [7:0] HDR_END  = 8'h80;
  localparam logic [7:0] HDR_FILL = 8'hFE;
  localparam logic [7:0] HDR_LONG = 8'hFF;

  localparam int unsigned CfgWidth = 17;
  localparam int unsigned OutWidth = 32;

endpackage

// ===== hdl/lcw_lz_stream_decoder_unit.sv =====
// Format80 LZ decoder. One request word is taken per clock: a feed, a pull, a stream
// start or a bad kind, and each gives exactly one result word in the next cycle through
// an output register, so the sustained rate is one word per cycle; while a result waits
// the input is held off, and it is taken again in the cycle that the result leaves.
// All decoded output lives in one history RAM of
// OUT_DEPTH bytes (one write port, one registered read port); a copy pull reads the
// RAM in the accept cycle and writes the byte back the cycle after, and a read that
// hits the byte still being written is forwarded. After reset the RAM is cleared to
// zero, one byte per cycle, and tready stays low until every address is cleared;
// configuration writes are taken during that time.
module lcw_lz_stream_decoder_unit #(
  parameter int unsigned OUT_DEPTH = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [lzsd_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // in_byte
  input  logic [1:0]                    s_axis_tuser,  // req_type
  input  logic                          s_axis_tlast,  // rom_last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_valid, out_addr[15:0], out_data[7:0], need_feed, stream_done, status[1:0]
  output logic [lzsd_pkg::OutWidth-1:0] m_axis_tdata
);
  import lzsd_pkg::*;

  localparam int unsigned AW = $clog2(OUT_DEPTH);
  localparam logic [16:0] Depth17 = 17'(OUT_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(OUT_DEPTH - 1);

  typedef enum logic [2:0] {
    PH_HEADER, PH_OPERANDS, PH_LITERAL, PH_COPY, PH_FILL, PH_DONE, PH_ERROR
  } phase_e;

  // configuration
  logic [16:0] limit_q;
  logic        fixed_q;
  logic [15:0] start_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [31:0] ob_q, ob_d;
  logic [2:0]  left_q, left_d;
  logic [15:0] run_q, run_d;
  logic [17:0] rp_q, rp_d;
  logic [16:0] wp_q, wp_d;
  logic [7:0]  fill_q, fill_d;
  logic [1:0]  err_q, err_d;
  logic        src_end_q, src_end_d;

  // result stage
  logic        ovld_q;
  logic        bvld_q, bvld_d;
  logic [15:0] addr_q, addr_d;
  logic        copy_q, copy_d;
  logic [7:0]  direct_q, direct_d;
  logic        fwd_q, fwd_d;
  logic [7:0]  fwd_data_q;
  logic        feed_q, feed_d;
  logic        done_q, done_d;
  logic [1:0]  stat_q, stat_d;
  logic        wr_pend_q;
  logic [AW-1:0] wr_addr_q;

  // memory and clear sweep
  logic [7:0]    hist_mem [OUT_DEPTH];
  logic [7:0]    rdata_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;
  logic          mem_re;
  logic [AW-1:0] rd_addr;
  logic [7:0]    byte_s2;

  logic        accept;
  logic [16:0] cap;

  function automatic logic needs_feed(phase_e p);
    return (p == PH_HEADER) || (p == PH_OPERANDS) || (p == PH_LITERAL);
  endfunction

  function automatic logic [2:0] op_total(logic [7:0] h);
    if (!h[7]) return 3'd1;
    if (h == HDR_FILL) return 3'd3;
    if (h == HDR_LONG) return 3'd4;
    return 3'd2;
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !clr_busy_q && (!ovld_q || m_axis_tready);
  assign cap           = (limit_q < Depth17) ? limit_q : Depth17;
  assign byte_s2       = copy_q ? (fwd_q ? fwd_data_q : rdata_q) : direct_q;

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {3'b000, stat_q, done_q, feed_q, byte_s2, addr_q, bvld_q};

  always_comb begin
    phase_e      ph;
    logic        do_put;
    logic        put_copy;
    logic [7:0]  put_val;
    logic [1:0]  k;
    logic [31:0] obn;
    logic [2:0]  left_n;
    logic [15:0] run_n;
    logic [11:0] off;
    logic [15:0] len;
    logic        readable;

    phase_d   = phase_q;
    hdr_d     = hdr_q;
    ob_d      = ob_q;
    left_d    = left_q;
    run_d     = run_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    err_d     = err_q;
    src_end_d = src_end_q;
    bvld_d    = 1'b0;
    addr_d    = '0;
    copy_d    = 1'b0;
    direct_d  = '0;
    stat_d    = ST_OK;
    mem_re    = 1'b0;
    rd_addr   = rp_q[AW-1:0];
    ph        = phase_q;
    do_put    = 1'b0;
    put_copy  = 1'b0;
    put_val   = '0;
    k         = 2'(op_total(hdr_q) - left_q);
    obn       = ob_q | (32'(s_axis_tdata) << {k, 3'b000});
    left_n    = left_q - 3'd1;
    run_n     = run_q - 16'd1;
    off       = {hdr_q[3:0], obn[7:0]};
    len       = '0;
    readable  = (rp_q < 18'(Depth17)) &&
                (fixed_q ? (rp_q < 18'(cap)) : (rp_q < 18'(wp_q)));

    if (accept) begin
      if (s_axis_tuser == REQ_START) begin
        ph        = PH_HEADER;
        hdr_d     = '0;
        ob_d      = '0;
        left_d    = '0;
        run_d     = '0;
        rp_d      = '0;
        wp_d      = {1'b0, start_q};
        fill_d    = '0;
        err_d     = ST_OK;
        src_end_d = 1'b0;
      end else if (s_axis_tuser == REQ_BAD) begin
        stat_d = ST_WRONG;
      end else if (phase_q == PH_ERROR) begin
        stat_d = err_q;
      end else if (phase_q == PH_DONE) begin
        stat_d = ST_WRONG;
      end else if (needs_feed(phase_q) != (s_axis_tuser == REQ_FEED)) begin
        stat_d = ST_WRONG;
      end else begin
        src_end_d = src_end_q || ((s_axis_tuser == REQ_FEED) && s_axis_tlast);
        if (s_axis_tuser == REQ_FEED) begin
          unique case (phase_q)
            PH_HEADER: begin
              hdr_d = s_axis_tdata;
              ob_d  = '0;
              if (s_axis_tdata == HDR_END) begin
                ph = PH_DONE;
              end else if (s_axis_tdata[7:6] == 2'b10) begin
                run_d = {10'd0, s_axis_tdata[5:0]};
                ph    = (s_axis_tdata[5:0] == 6'd0) ? PH_HEADER : PH_LITERAL;
              end else begin
                left_d = op_total(s_axis_tdata);
                ph     = PH_OPERANDS;
              end
            end
            PH_OPERANDS: begin
              ob_d   = obn;
              left_d = left_n;
              if (left_n == 3'd0) begin
                if (!hdr_q[7]) begin
                  if ((17'(off) > wp_q) || ((off == 12'd0) && !fixed_q)) begin
                    ph    = PH_ERROR;
                    err_d = ST_CORRUPT;
                  end else begin
                    rp_d  = 18'(wp_q - 17'(off));
                    run_d = 16'(hdr_q[6:4]) + 16'd3;
                    ph    = PH_COPY;
                  end
                end else if (hdr_q == HDR_FILL) begin
                  fill_d = obn[23:16];
                  run_d  = obn[15:0];
                  ph     = (obn[15:0] == 16'd0) ? PH_HEADER : PH_FILL;
                end else if (hdr_q == HDR_LONG) begin
                  rp_d  = 18'(start_q) + 18'(obn[31:16]);
                  run_d = obn[15:0];
                  ph    = (obn[15:0] == 16'd0) ? PH_HEADER : PH_COPY;
                end else begin
                  len   = 16'(hdr_q[5:0]) + 16'd3;
                  rp_d  = 18'(start_q) + 18'(obn[15:0]);
                  run_d = len;
                  ph    = PH_COPY;
                end
              end
            end
            default: begin
              do_put  = 1'b1;
              put_val = s_axis_tdata;
            end
          endcase
        end else if (phase_q == PH_COPY) begin
          if (!readable) begin
            ph    = PH_ERROR;
            err_d = ST_CORRUPT;
          end else begin
            do_put   = 1'b1;
            put_copy = 1'b1;
          end
        end else begin
          do_put  = 1'b1;
          put_val = fill_q;
        end

        if (do_put) begin
          if (wp_q >= cap) begin
            ph    = PH_ERROR;
            err_d = fixed_q ? ST_CORRUPT : ST_LIMIT;
          end else begin
            bvld_d   = 1'b1;
            addr_d   = wp_q[15:0];
            copy_d   = put_copy;
            direct_d = put_val;
            mem_re   = put_copy;
            wp_d     = wp_q + 17'd1;
            run_d    = run_n;
            if (put_copy) rp_d = rp_q + 18'd1;
            if (run_n == 16'd0) ph = PH_HEADER;
          end
        end

        // running out of source while a byte is still due
        if (needs_feed(ph) && src_end_d) begin
          ph    = PH_ERROR;
          err_d = ST_CORRUPT;
        end
        if (ph == PH_ERROR) stat_d = err_d;
      end
    end

    phase_d = ph;
    feed_d  = needs_feed(ph);
    done_d  = (ph == PH_DONE);
    fwd_d   = mem_re && wr_pend_q && (wr_addr_q == rd_addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= 17'h10000;
      fixed_q    <= 1'b0;
      start_q    <= '0;
      phase_q    <= PH_HEADER;
      hdr_q      <= '0;
      ob_q       <= '0;
      left_q     <= '0;
      run_q      <= '0;
      rp_q       <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      err_q      <= ST_OK;
      src_end_q  <= 1'b0;
      ovld_q     <= 1'b0;
      wr_pend_q  <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LIMIT: limit_q <= cfg_data_i;
          CFG_FIXED: fixed_q <= cfg_data_i[0];
          CFG_START: start_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == LastAddr) clr_busy_q <= 1'b0;
      end
      phase_q   <= phase_d;
      hdr_q     <= hdr_d;
      ob_q      <= ob_d;
      left_q    <= left_d;
      run_q     <= run_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      err_q     <= err_d;
      src_end_q <= src_end_d;
      wr_pend_q <= accept && bvld_d;
      if (accept) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // result stage payload, loaded only on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bvld_q     <= bvld_d;
      addr_q     <= addr_d;
      copy_q     <= copy_d;
      direct_q   <= direct_d;
      fwd_q      <= fwd_d;
      fwd_data_q <= byte_s2;
      feed_q     <= feed_d;
      done_q     <= done_d;
      stat_q     <= stat_d;
      wr_addr_q  <= wp_q[AW-1:0];
    end
  end

  // history RAM: clear sweep or byte write-back on the write port
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      hist_mem[clr_cnt_q] <= '0;
    end else if (wr_pend_q) begin
      hist_mem[wr_addr_q] <= byte_s2;
    end
    if (mem_re) begin
      rdata_q <= hist_mem[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input taken during clear sweep");

  a_wb_after_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (!clr_busy_q && ovld_q))
    else $error("write-back without a result in the output stage");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_error_code_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR) |-> (err_q != ST_OK))
    else $error("error phase without an error code");

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (rp_q < 18'(Depth17)))
    else $error("history read beyond depth");
`endif

endmodule

// ===== verif/lcw_lz_stream_decoder_unit_test.sv =====
module lcw_lz_stream_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lzsd_pkg::*;

  localparam int StallLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int PhaseWords = 48;

  typedef enum logic [2:0] {
    PH_HEAD, PH_OPND, PH_LIT, PH_COPY, PH_FILL, PH_DONE, PH_ERR
  } dec_phase_e;

  // same layout as m_axis_tdata[28:0]
  typedef struct packed {
    logic [1:0]  status;
    logic        done;
    logic        need_feed;
    logic [7:0]  data;
    logic [15:0] addr;
    logic        valid;
  } lz_res_t;

  typedef struct packed {
    logic [1:0] rt;
    logic [7:0] b;
    logic       last;
    logic       pin;
    lz_res_t    want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = CFG_LIMIT;
  logic [CfgWidth-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic [1:0]          s_axis_tuser = REQ_FEED;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  lcw_lz_stream_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // decoder mirror
  dec_phase_e  pr_ph = PH_HEAD;
  logic [7:0]  pr_hdr = 8'h00;
  logic [31:0] pr_ops = '0;
  logic [2:0]  pr_left = '0;
  logic [15:0] pr_run = '0;
  logic [16:0] pr_rd = '0;
  logic [16:0] pr_wr = '0;
  logic [7:0]  pr_fill = 8'h00;
  logic [1:0]  pr_err = ST_OK;
  logic        pr_src_end = 1'b0;
  logic [7:0]  hist_mem [0:65535];
  logic [16:0] cfg_limit = 17'd65536;
  logic        cfg_fixed = 1'b0;
  logic [15:0] cfg_base = 16'd0;
  lz_res_t     dec_res;

  lz_res_t     exp_q [$];
  int          n_fail = 0;
  int          n_words_in = 0;
  int          n_words_out = 0;
  int          n_bytes = 0;
  int          n_status [4] = '{0, 0, 0, 0};
  int          stall_cnt = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  bit          calm = 1'b0;

  function automatic logic [16:0] write_cap();
    return (cfg_limit < 17'd65536) ? cfg_limit : 17'd65536;
  endfunction

  function automatic logic feed_due(dec_phase_e p);
    return p == PH_HEAD || p == PH_OPND || p == PH_LIT;
  endfunction

  function automatic logic [2:0] operand_count(logic [7:0] h);
    if (!h[7]) return 3'd1;
    if (h == HDR_FILL) return 3'd3;
    if (h == HDR_LONG) return 3'd4;
    return 3'd2;
  endfunction

  function automatic void set_error(logic [1:0] code);
    pr_ph = PH_ERR;
    pr_err = code;
  endfunction

  function automatic logic can_read(logic [16:0] a);
    if (a >= 17'd65536) return 1'b0;
    return cfg_fixed ? (a < write_cap()) : (a < pr_wr);
  endfunction

  function automatic logic store_byte(logic [7:0] v);
    if (pr_wr >= write_cap()) begin
      set_error(cfg_fixed ? ST_CORRUPT : ST_LIMIT);
      return 1'b0;
    end
    hist_mem[pr_wr[15:0]] = v;
    dec_res.valid = 1'b1;
    dec_res.addr = pr_wr[15:0];
    dec_res.data = v;
    pr_wr = pr_wr + 17'd1;
    return 1'b1;
  endfunction

  function automatic void begin_run(dec_phase_e nxt, logic [15:0] len);
    pr_run = len;
    pr_ph = (len == 16'd0) ? PH_HEAD : nxt;
  endfunction

  function automatic void run_step();
    pr_run = pr_run - 16'd1;
    if (pr_run == 16'd0) pr_ph = PH_HEAD;
  endfunction

  function automatic void decode_operands();
    logic [11:0] off;
    off = {pr_hdr[3:0], pr_ops[7:0]};
    if (!pr_hdr[7]) begin
      // short copy, offset back from the write position
      if ({5'd0, off} > pr_wr || (off == 12'd0 && !cfg_fixed)) begin
        set_error(ST_CORRUPT);
      end else begin
        pr_rd = pr_wr - {5'd0, off};
        begin_run(PH_COPY, {13'd0, pr_hdr[6:4]} + 16'd3);
      end
    end else if (pr_hdr == HDR_FILL) begin
      pr_fill = pr_ops[23:16];
      begin_run(PH_FILL, pr_ops[15:0]);
    end else if (pr_hdr == HDR_LONG) begin
      pr_rd = {1'b0, cfg_base} + {1'b0, pr_ops[31:16]};
      begin_run(PH_COPY, pr_ops[15:0]);
    end else begin
      pr_rd = {1'b0, cfg_base} + {1'b0, pr_ops[15:0]};
      begin_run(PH_COPY, {10'd0, pr_hdr[5:0]} + 16'd3);
    end
  endfunction

  function automatic void predict(logic [1:0] rt, logic [7:0] b, logic last);
    logic [1:0] st;
    logic [1:0] k;
    dec_res = '0;
    st = ST_OK;
    if (rt == REQ_START) begin
      pr_ph = PH_HEAD;
      pr_hdr = 8'h00;
      pr_ops = '0;
      pr_left = '0;
      pr_run = '0;
      pr_rd = '0;
      pr_wr = {1'b0, cfg_base};
      pr_fill = 8'h00;
      pr_err = ST_OK;
      pr_src_end = 1'b0;
    end else if (rt == REQ_BAD) begin
      st = ST_WRONG;
    end else if (pr_ph == PH_ERR) begin
      st = pr_err;
    end else if (pr_ph == PH_DONE) begin
      st = ST_WRONG;
    end else if (feed_due(pr_ph) != (rt == REQ_FEED)) begin
      st = ST_WRONG;
    end else begin
      if (rt == REQ_FEED) begin
        if (last) pr_src_end = 1'b1;
        if (pr_ph == PH_HEAD) begin
          pr_hdr = b;
          pr_ops = '0;
          if (b == HDR_END) begin
            pr_ph = PH_DONE;
          end else if (b[7:6] == 2'b10) begin
            begin_run(PH_LIT, {10'd0, b[5:0]});
          end else begin
            pr_left = operand_count(b);
            pr_ph = PH_OPND;
          end
        end else if (pr_ph == PH_OPND) begin
          k = 2'(operand_count(pr_hdr) - pr_left);
          pr_ops = pr_ops | ({24'd0, b} << (8 * k));
          pr_left = pr_left - 3'd1;
          if (pr_left == 3'd0) decode_operands();
        end else if (store_byte(b)) begin
          run_step();
        end
      end else if (pr_ph == PH_COPY) begin
        if (!can_read(pr_rd)) begin
          set_error(ST_CORRUPT);
        end else if (store_byte(hist_mem[pr_rd[15:0]])) begin
          pr_rd = pr_rd + 17'd1;
          run_step();
        end
      end else if (store_byte(pr_fill)) begin
        run_step();
      end
      // a byte marked last was already taken and another one is needed
      if (feed_due(pr_ph) && pr_src_end) set_error(ST_CORRUPT);
      if (pr_ph == PH_ERR) st = pr_err;
    end
    dec_res.need_feed = feed_due(pr_ph);
    dec_res.done = (pr_ph == PH_DONE);
    dec_res.status = st;
  endfunction

  task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      $display("%t: %s mismatch, expected %h, got %h", $time, name, e, a);
      n_fail++;
    end
  endtask

  task automatic check_word(input logic [OutWidth-1:0] d);
    lz_res_t got;
    lz_res_t want;
    got = d[28:0];
    n_words_out++;
    if (got.valid === 1'b1) n_bytes++;
    if (!$isunknown(got.status)) n_status[got.status]++;
    if (exp_q.size() == 0) begin
      $display("%t: result word %h with nothing expected", $time, d);
      n_fail++;
    end else begin
      want = exp_q.pop_front();
      cmp_field("out_valid", 16'(want.valid), 16'(got.valid));
      cmp_field("out_addr", want.addr, got.addr);
      cmp_field("out_data", 16'(want.data), 16'(got.data));
      cmp_field("need_feed", 16'(want.need_feed), 16'(got.need_feed));
      cmp_field("stream_done", 16'(want.done), 16'(got.done));
      cmp_field("status", 16'(want.status), 16'(got.status));
    end
  endtask

  // result side: check, then pick the next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen++;
      hold_cnt = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("%t: no word moved for %0d cycles", $time, stall_cnt);
      $display("lcw_lz_stream_decoder_unit_test: FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] rt, input logic [7:0] b, input logic last,
                           input logic pin, input lz_res_t want);
    while (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rt;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict(rt, b, last);
    exp_q.insert(exp_q.size(), pin ? want : dec_res);
    n_words_in++;
  endtask

  task automatic feed(input logic [7:0] b);
    send_word(REQ_FEED, b, $urandom_range(59) == 0, 1'b0, '0);
  endtask

  task automatic pull();
    send_word(REQ_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [16:0] lim, input logic fix, input logic [15:0] base);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    cfg_limit = lim;
    cfg_idx_i <= CFG_FIXED;
    cfg_data_i <= {16'd0, fix};
    @(posedge clk_i);
    cfg_fixed = fix;
    cfg_idx_i <= CFG_START;
    cfg_data_i <= {1'b0, base};
    @(posedge clk_i);
    cfg_base = base;
    cfg_we_i <= 1'b0;
  endtask

  // one stream: start, a few commands with their pulls, mostly an end code
  task automatic gen_stream();
    int ncmd;
    int span;
    int len;
    logic [15:0] off;
    send_word(REQ_START, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
    ncmd = $urandom_range(1, 8);
    for (int i = 0; i < ncmd; i++) begin
      if (pr_ph == PH_DONE || pr_ph == PH_ERR) break;
      span = int'(pr_wr) - int'(cfg_base);
      case ($urandom_range(9))
        0, 1, 2: begin
          len = ($urandom_range(9) == 0) ? 63 : $urandom_range(1, 8);
          feed(8'h80 | 8'(len));
          repeat (len) feed(8'($urandom_range(255)));
        end
        3, 4, 5: begin
          off = (span > 0 && $urandom_range(7) != 0) ?
                16'($urandom_range(1, (span < 4095) ? span : 4095)) :
                16'($urandom_range(4095));
          feed({1'b0, 3'($urandom_range(7)), off[11:8]});
          feed(off[7:0]);
        end
        6: begin
          off = (span > 0 && $urandom_range(7) != 0) ?
                16'($urandom_range(span - 1)) : 16'($urandom);
          feed({2'b11, 6'($urandom_range(61))});
          feed(off[7:0]);
          feed(off[15:8]);
        end
        7: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(12);
          feed(HDR_FILL);
          feed(8'(len));
          feed(8'(len >> 8));
          feed(8'($urandom_range(255)));
        end
        8: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(12);
          off = (span > 0 && $urandom_range(7) != 0) ?
                16'($urandom_range(span - 1)) : 16'($urandom);
          feed(HDR_LONG);
          feed(8'(len));
          feed(8'(len >> 8));
          feed(off[7:0]);
          feed(off[15:8]);
        end
        default: begin
          send_word(2'($urandom_range(3)), 8'($urandom_range(255)),
                    $urandom_range(7) == 0, 1'b0, '0);
        end
      endcase
      while (pr_ph == PH_COPY || pr_ph == PH_FILL) pull();
    end
    if (pr_ph == PH_HEAD && $urandom_range(9) < 7) feed(HDR_END);
    // poke a finished or broken stream now and then
    if ((pr_ph == PH_DONE || pr_ph == PH_ERR) && $urandom_range(3) == 0)
      send_word(2'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0, '0);
  endtask

  function automatic dir_row_t free_row(logic [1:0] rt, logic [7:0] b, logic last);
    return '{rt: rt, b: b, last: last, pin: 1'b0, want: '0};
  endfunction

  function automatic dir_row_t pin_row(logic [1:0] rt, logic [7:0] b, logic last,
                                       logic v, logic [15:0] a, logic [7:0] d,
                                       logic nf, logic dn, logic [1:0] st);
    lz_res_t w;
    w.valid = v;
    w.addr = a;
    w.data = d;
    w.need_feed = nf;
    w.done = dn;
    w.status = st;
    return '{rt: rt, b: b, last: last, pin: 1'b1, want: w};
  endfunction

  initial begin
    dir_row_t dir_tab [23];
    int phase_first;
    bit held;
    foreach (hist_mem[i]) hist_mem[i] = 8'h00;

    dir_tab = '{
      pin_row(REQ_PULL, 8'h00, 1'b0, 1'b0, 16'd0, 8'h00, 1'b1, 1'b0, ST_WRONG),
      pin_row(REQ_BAD, 8'hA5, 1'b1, 1'b0, 16'd0, 8'h00, 1'b1, 1'b0, ST_WRONG),
      pin_row(REQ_START, 8'h00, 1'b0, 1'b0, 16'd0, 8'h00, 1'b1, 1'b0, ST_OK),
      pin_row(REQ_FEED, 8'h82, 1'b0, 1'b0, 16'd0, 8'h00, 1'b1, 1'b0, ST_OK),
      pin_row(REQ_FEED, 8'h00, 1'b0, 1'b1, 16'd0, 8'h00, 1'b1, 1'b0, ST_OK),
      pin_row(REQ_FEED, 8'hFF, 1'b0, 1'b1, 16'd1, 8'hFF, 1'b1, 1'b0, ST_OK),
      // short copy of three, two back, overlapping its own output
      free_row(REQ_FEED, 8'h00, 1'b0),
      free_row(REQ_FEED, 8'h02, 1'b0),
      free_row(REQ_PULL, 8'h00, 1'b0),
      free_row(REQ_PULL, 8'hFF, 1'b1),
      free_row(REQ_PULL, 8'h00, 1'b0),
      // zero-count fill
      free_row(REQ_FEED, HDR_FILL, 1'b0),
      free_row(REQ_FEED, 8'h00, 1'b0),
      free_row(REQ_FEED, 8'h00, 1'b0),
      free_row(REQ_FEED, 8'h5A, 1'b0),
      pin_row(REQ_FEED, HDR_END, 1'b0, 1'b0, 16'd0, 8'h00, 1'b0, 1'b1, ST_OK),
      pin_row(REQ_FEED, 8'h7F, 1'b0, 1'b0, 16'd0, 8'h00, 1'b0, 1'b1, ST_WRONG),
      // zero offset in growing mode
      pin_row(REQ_START, 8'h00, 1'b0, 1'b0, 16'd0, 8'h00, 1'b1, 1'b0, ST_OK),
      free_row(REQ_FEED, 8'h00, 1'b0),
      pin_row(REQ_FEED, 8'h00, 1'b0, 1'b0, 16'd0, 8'h00, 1'b0, 1'b0, ST_CORRUPT),
      pin_row(REQ_PULL, 8'h00, 1'b0, 1'b0, 16'd0, 8'h00, 1'b0, 1'b0, ST_CORRUPT),
      // source runs out right after a literal header
      pin_row(REQ_START, 8'h00, 1'b0, 1'b0, 16'd0, 8'h00, 1'b1, 1'b0, ST_OK),
      pin_row(REQ_FEED, 8'h81, 1'b1, 1'b0, 16'd0, 8'h00, 1'b0, 1'b0, ST_CORRUPT)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_word(dir_tab[i].rt, dir_tab[i].b, dir_tab[i].last, dir_tab[i].pin, dir_tab[i].want);

    for (int p = 0; p < 7; p++) begin
      drain();
      calm = (p == 1);
      case (p)
        1: set_config(17'd65536, 1'b1, 16'd0);
        2: set_config(17'd0, 1'b0, 16'd65535);
        3: set_config(17'd300, 1'b0, 16'd100);
        4: set_config(17'd2000, 1'b1, 16'd1500);
        5: set_config(17'd65536, 1'b0, 16'd65535);
        6: set_config(17'($urandom_range(256, 65536)), 1'($urandom_range(1)),
                      16'($urandom_range(65535)));
        default: ;
      endcase
      phase_first = n_words_in;
      held = 1'b0;
      while (n_words_in - phase_first < PhaseWords) begin
        // long output stall while the input keeps offering words
        if (p == 3 && !held) begin
          hold_req++;
          held = 1'b1;
        end
        gen_stream();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    n_fail += exp_q.size();
    $display("%0d request words in, %0d result words out, %0d bytes decoded, 7 settings",
             n_words_in, n_words_out, n_bytes);
    $display("status ok/corrupt/limit/wrong seen: %0d/%0d/%0d/%0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_fail == 0) begin
      $display("lcw_lz_stream_decoder_unit_test: PASS");
    end else begin
      $display("lcw_lz_stream_decoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== lcw_lz_stream_decoder_unit.f =====
hdl/lzsd_pkg.sv
hdl/lcw_lz_stream_decoder_unit.sv
verif/lcw_lz_stream_decoder_unit_test.sv
